// File: hw/rtl/round_robin_voice_allocator_macros.svh
// Assertion macros shared by the voice allocator RTL.
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_MACROS_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define RRVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RRVA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RRVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RRVA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/rrva_pkg.sv
// Package with types and constants of the round-robin voice allocator.
package rrva_pkg;

	// Default number of voice slots.
	localparam int NUM_SLOTS_DEF = 7;

	// Field widths of the event and result transactions.
	localparam int FUNC_W    = 2;
	localparam int NOTE_W    = 7;
	localparam int MASK_W    = 7;
	localparam int IDX_OUT_W = 3;
	localparam int STAMP_W   = 32;

	// Register port: one 32-bit register, three address bits.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_SLOT_ENABLE = '0;
	localparam logic [MASK_W-1:0]  MASK_RESET      = MASK_W'(1);

	// Event kinds.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_NOTE_ON  = 2'd0,
		FUNC_NOTE_OFF = 2'd1,
		FUNC_ALL_OFF  = 2'd2
	} func_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic res_busy;
	} sts_t;

endpackage

// File: hw/rtl/rrva_ctrl.sv
// Controller state machine of the voice allocator.
`include "round_robin_voice_allocator_macros.svh"
module rrva_ctrl
	import rrva_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: take an event, scan every slot once, then commit.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!sts.res_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: the commit waits until the result register is free.
	always_comb begin
		cmd       = '0;
		evt_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				evt_stall = 1'b0;
				cmd.load  = evt_valid;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = !sts.res_busy;
			end
			default: begin
				evt_stall = 1'b1;
			end
		endcase
	end

	`RRVA_ASSERT_NXT(a_load_scans, clk, arst_n, cmd.load, state_q == ST_SCAN, "load did not start a scan")
	`RRVA_ASSERT_NXT(a_commit_idles, clk, arst_n, cmd.commit, !evt_stall, "commit did not return to idle")
	`RRVA_ASSERT_IMP(a_stall_when_busy, clk, arst_n, state_q != ST_IDLE, evt_stall, "event taken while busy")

endmodule

// File: hw/rtl/rrva_dp.sv
// Datapath of the voice allocator: slot store, slot scan and result register.
`include "round_robin_voice_allocator_macros.svh"
module rrva_dp
	import rrva_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [FUNC_W-1:0]    func,
	input  logic [NOTE_W-1:0]    note,
	input  logic [MASK_W-1:0]    enable_mask,
	input  logic                 res_stall,
	output logic                 res_valid,
	output logic                 slot_valid,
	output logic [IDX_OUT_W-1:0] slot_index,
	output logic                 stolen,
	output logic                 dropped,
	output logic [NOTE_W-1:0]    assigned_note,
	output logic [MASK_W-1:0]    active_mask
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// Event being processed.
	func_t             func_q;
	logic [NOTE_W-1:0] note_q;

	// Slot store and allocation state.
	logic [NOTE_W-1:0]  note_arr_q [NUM_SLOTS];
	logic [STAMP_W-1:0] stamp_arr_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] active_q;
	logic [SLOT_W-1:0]  search_q;
	logic [STAMP_W-1:0] stamp_cnt_q;

	// Scan state.
	logic [SLOT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic               free_found_q;
	logic [SLOT_W-1:0]  free_idx_q;
	logic               have_q;
	logic [STAMP_W-1:0] best_q;
	logic [SLOT_W-1:0]  best_idx_q;
	logic               match_found_q;
	logic [SLOT_W-1:0]  match_idx_q;

	// Result register.
	logic                 res_valid_q;
	logic                 slot_valid_q;
	logic [IDX_OUT_W-1:0] slot_index_q;
	logic                 stolen_q;
	logic                 dropped_q;
	logic [NOTE_W-1:0]    assigned_note_q;
	logic [MASK_W-1:0]    active_mask_q;

	// Enabled slots: only the first MASK_W slots have an enable bit.
	logic [NUM_SLOTS+MASK_W-1:0] en_pad;
	logic [NUM_SLOTS-1:0]        en;
	assign en_pad = {NUM_SLOTS'(0), enable_mask};
	assign en     = en_pad[NUM_SLOTS-1:0];

	// One slot per scan step, visited in round-robin order from the search start.
	logic               cur_en;
	logic               cur_act;
	logic [STAMP_W-1:0] cur_stamp;
	logic [NOTE_W-1:0]  cur_note;
	logic               take_free;
	logic               take_best;
	logic               take_match;
	logic [SLOT_W-1:0]  ptr_nxt;

	assign cur_en    = en[ptr_q];
	assign cur_act   = active_q[ptr_q];
	assign cur_stamp = stamp_arr_q[ptr_q];
	assign cur_note  = note_arr_q[ptr_q];
	assign ptr_nxt   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + SLOT_W'(1);

	// First free slot in scan order; oldest stamp with ties to the lowest index;
	// lowest active slot that holds the note.
	assign take_free  = cur_en && !cur_act && !free_found_q;
	assign take_best  = cur_en && (!have_q || (cur_stamp < best_q) ||
		((cur_stamp == best_q) && (ptr_q < best_idx_q)));
	assign take_match = cur_act && (cur_note == note_q) &&
		(!match_found_q || (ptr_q < match_idx_q));

	assign sts.scan_last = (cnt_q == '0);
	assign sts.res_busy  = res_valid_q && res_stall;

	// Outcome of the event, applied at commit.
	logic                 any_en;
	logic [SLOT_W-1:0]    chosen;
	logic [SLOT_W-1:0]    chosen_nxt;
	logic [STAMP_W-1:0]   stamp_inc;
	logic                 assign_slot;
	logic                 r_valid;
	logic [SLOT_W-1:0]    r_index;
	logic                 r_stolen;
	logic                 r_dropped;
	logic [NOTE_W-1:0]    r_note;
	logic [NUM_SLOTS-1:0] act_next;
	logic [NUM_SLOTS+MASK_W-1:0] act_pad;

	assign any_en     = |en;
	assign chosen     = free_found_q ? free_idx_q : best_idx_q;
	assign chosen_nxt = (chosen == LAST_SLOT) ? '0 : chosen + SLOT_W'(1);
	assign stamp_inc  = stamp_cnt_q + STAMP_W'(1);
	assign act_pad    = {MASK_W'(0), act_next};

	// Decode of the event kind.
	always_comb begin
		assign_slot = 1'b0;
		r_valid     = 1'b0;
		r_index     = '0;
		r_stolen    = 1'b0;
		r_dropped   = 1'b0;
		r_note      = '0;
		act_next    = active_q;
		unique case (func_q)
			FUNC_NOTE_ON: begin
				if (any_en) begin
					assign_slot      = 1'b1;
					r_valid          = 1'b1;
					r_index          = chosen;
					r_stolen         = !free_found_q;
					r_note           = note_q;
					act_next[chosen] = 1'b1;
				end else begin
					r_dropped = 1'b1;
				end
			end
			FUNC_NOTE_OFF: begin
				if (match_found_q) begin
					r_valid               = 1'b1;
					r_index               = match_idx_q;
					act_next[match_idx_q] = 1'b0;
				end
			end
			FUNC_ALL_OFF: begin
				act_next = '0;
			end
			default: begin
				act_next = active_q;
			end
		endcase
	end

	// Event capture, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			note_q <= note;
		end
	end

	// Scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			ptr_q         <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			have_q        <= 1'b0;
			best_q        <= '0;
			best_idx_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
		end else if (cmd.load) begin
			cnt_q         <= LAST_SLOT;
			ptr_q         <= search_q;
			free_found_q  <= 1'b0;
			have_q        <= 1'b0;
			match_found_q <= 1'b0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - SLOT_W'(1);
			ptr_q <= ptr_nxt;
			if (take_free) begin
				free_found_q <= 1'b1;
				free_idx_q   <= ptr_q;
			end
			if (take_best) begin
				have_q     <= 1'b1;
				best_q     <= cur_stamp;
				best_idx_q <= ptr_q;
			end
			if (take_match) begin
				match_found_q <= 1'b1;
				match_idx_q   <= ptr_q;
			end
		end
	end

	// Slot store and allocation state, updated at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				note_arr_q[i]  <= '0;
				stamp_arr_q[i] <= '0;
			end
			active_q    <= '0;
			search_q    <= '0;
			stamp_cnt_q <= '0;
		end else if (cmd.commit) begin
			active_q <= act_next;
			if (assign_slot) begin
				note_arr_q[chosen]  <= note_q;
				stamp_arr_q[chosen] <= stamp_inc;
				stamp_cnt_q         <= stamp_inc;
				search_q            <= chosen_nxt;
			end
		end
	end

	// Result register: loaded at commit, emptied when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_valid_q    <= r_valid;
			slot_index_q    <= IDX_OUT_W'(r_index);
			stolen_q        <= r_stolen;
			dropped_q       <= r_dropped;
			assigned_note_q <= r_note;
			active_mask_q   <= act_pad[MASK_W-1:0];
		end
	end

	assign res_valid     = res_valid_q;
	assign slot_valid    = slot_valid_q;
	assign slot_index    = slot_index_q;
	assign stolen        = stolen_q;
	assign dropped       = dropped_q;
	assign assigned_note = assigned_note_q;
	assign active_mask   = active_mask_q;

	`RRVA_ASSERT_IMP(a_steal_assigns, clk, arst_n, res_valid_q && stolen_q, slot_valid_q && !dropped_q, "steal without an assigned slot")
	`RRVA_ASSERT_IMP(a_drop_no_enable, clk, arst_n, res_valid_q && dropped_q, en == '0, "drop while a slot is enabled")
	`RRVA_ASSERT_NXT(a_stamp_on_commit, clk, arst_n, !cmd.commit, $stable(stamp_cnt_q), "stamp counter moved outside commit")

endmodule

// File: hw/rtl/round_robin_voice_allocator.sv
// Top level of the round-robin voice allocator with oldest-slot stealing.
//
// Events enter on the evt channel (func, note) and are taken when evt_valid
// is high and evt_stall is low. Each event yields exactly one result
// transaction on the res channel, taken when res_valid is high and res_stall
// is low. An event scans the NUM_SLOTS slots one per cycle through a single
// read port on the slot store, then commits; evt_stall stays high from the
// scan until the commit, so a new event is taken only after the previous
// one has committed.
// The next event is taken while a finished result still waits; its commit
// holds while res_stall keeps the earlier result in the output register.
// slot_enable_mask sits at byte address 0 of the register port; write it
// only while no event is in flight. Reset frees every slot, clears the
// notes, stamps, search start and stamp counter, and enables slot 0 only.
module round_robin_voice_allocator
	import rrva_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  logic [FUNC_W-1:0]    func,
	input  logic [NOTE_W-1:0]    note,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 slot_valid,
	output logic [IDX_OUT_W-1:0] slot_index,
	output logic                 stolen,
	output logic                 dropped,
	output logic [NOTE_W-1:0]    assigned_note,
	output logic [MASK_W-1:0]    active_mask,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	cmd_t              cmd;
	sts_t              sts;
	logic [MASK_W-1:0] enable_mask_q;
	logic              reg_hit;

	// Register decode: the index is the word address.
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_SLOT_ENABLE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? PDATA_W'(enable_mask_q) : '0;

	// Slot enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			enable_mask_q <= pwdata[MASK_W-1:0];
		end
	end

	rrva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrva_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.note          (note),
		.enable_mask   (enable_mask_q),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.slot_valid    (slot_valid),
		.slot_index    (slot_index),
		.stolen        (stolen),
		.dropped       (dropped),
		.assigned_note (assigned_note),
		.active_mask   (active_mask)
	);

endmodule
